// ===== sv/mcnd_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mcnd_pkg
// Shared widths and item types for the cheapest two-pack split core.
// ----------------------------------------------------------------------------
package mcnd_pkg;

  localparam int unsigned VALUE_W = 32;
  localparam int unsigned WIDE_W  = 2 * VALUE_W;
  localparam int unsigned T_W     = VALUE_W + 2;

  typedef struct packed {
    logic [VALUE_W-1:0] total;
    logic [VALUE_W-1:0] cost_a;
    logic [VALUE_W-1:0] size_a;
    logic [VALUE_W-1:0] cost_b;
    logic [VALUE_W-1:0] size_b;
  } in_item_t;

  typedef struct packed {
    logic               failed;
    logic [VALUE_W-1:0] count_a;
    logic [VALUE_W-1:0] count_b;
  } result_t;

endpackage

// ===== sv/mcnd_div.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mcnd_div
// Restoring divider, one quotient bit per cycle; narrow or double-width
// dividend.
// ----------------------------------------------------------------------------
module mcnd_div (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         go_i,
  input  logic                         wide_i,
  input  logic [mcnd_pkg::WIDE_W-1:0]  dividend_i,
  input  logic [mcnd_pkg::VALUE_W-1:0] divisor_i,
  output logic                         done_o,
  output logic [mcnd_pkg::WIDE_W-1:0]  quot_o,
  output logic [mcnd_pkg::VALUE_W-1:0] rem_o
);

  localparam int unsigned CntW = $clog2(mcnd_pkg::WIDE_W + 1);

  logic [mcnd_pkg::WIDE_W-1:0]  d_q, d_d;
  logic [mcnd_pkg::VALUE_W-1:0] rem_q, rem_d;
  logic [mcnd_pkg::VALUE_W-1:0] dvs_q, dvs_d;
  logic [CntW-1:0]              cnt_q, cnt_d;
  logic                         run_q, run_d;
  logic                         done_q, done_d;
  logic [mcnd_pkg::VALUE_W:0]   trial;
  logic                         fits;

  assign trial = {rem_q, d_q[mcnd_pkg::WIDE_W-1]};
  assign fits  = trial >= {1'b0, dvs_q};

  always_comb begin
    d_d    = d_q;
    rem_d  = rem_q;
    dvs_d  = dvs_q;
    cnt_d  = cnt_q;
    run_d  = run_q;
    done_d = 1'b0;
    if (go_i) begin
      run_d = 1'b1;
      rem_d = '0;
      dvs_d = divisor_i;
      if (wide_i) begin
        d_d   = dividend_i;
        cnt_d = CntW'(mcnd_pkg::WIDE_W);
      end else begin
        d_d   = {dividend_i[mcnd_pkg::VALUE_W-1:0], {mcnd_pkg::VALUE_W{1'b0}}};
        cnt_d = CntW'(mcnd_pkg::VALUE_W);
      end
    end else if (run_q) begin
      rem_d = fits ? mcnd_pkg::VALUE_W'(trial - {1'b0, dvs_q})
                   : trial[mcnd_pkg::VALUE_W-1:0];
      d_d   = {d_q[mcnd_pkg::WIDE_W-2:0], fits};
      cnt_d = cnt_q - 1'b1;
      if (cnt_q == CntW'(1)) begin
        run_d  = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      run_q  <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      run_q  <= run_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    d_q   <= d_d;
    rem_q <= rem_d;
    dvs_q <= dvs_d;
  end

  assign done_o = done_q;
  assign quot_o = d_q;
  assign rem_o  = rem_q;

endmodule

// ===== sv/mcnd_mul.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mcnd_mul
// Shift-add multiplier, one multiplier bit per cycle, double-width product.
// ----------------------------------------------------------------------------
module mcnd_mul (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         go_i,
  input  logic [mcnd_pkg::VALUE_W-1:0] a_i,
  input  logic [mcnd_pkg::VALUE_W-1:0] b_i,
  output logic                         done_o,
  output logic [mcnd_pkg::WIDE_W-1:0]  prod_o
);

  localparam int unsigned CntW = $clog2(mcnd_pkg::VALUE_W + 1);

  logic [mcnd_pkg::WIDE_W-1:0]  acc_q, acc_d;
  logic [mcnd_pkg::WIDE_W-1:0]  mcand_q, mcand_d;
  logic [mcnd_pkg::VALUE_W-1:0] mplier_q, mplier_d;
  logic [CntW-1:0]              cnt_q, cnt_d;
  logic                         run_q, run_d;
  logic                         done_q, done_d;

  always_comb begin
    acc_d    = acc_q;
    mcand_d  = mcand_q;
    mplier_d = mplier_q;
    cnt_d    = cnt_q;
    run_d    = run_q;
    done_d   = 1'b0;
    if (go_i) begin
      acc_d    = '0;
      mcand_d  = mcnd_pkg::WIDE_W'(a_i);
      mplier_d = b_i;
      cnt_d    = CntW'(mcnd_pkg::VALUE_W);
      run_d    = 1'b1;
    end else if (run_q) begin
      if (mplier_q[0]) begin
        acc_d = acc_q + mcand_q;
      end
      mcand_d  = {mcand_q[mcnd_pkg::WIDE_W-2:0], 1'b0};
      mplier_d = {1'b0, mplier_q[mcnd_pkg::VALUE_W-1:1]};
      cnt_d    = cnt_q - 1'b1;
      if (cnt_q == CntW'(1)) begin
        run_d  = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      run_q  <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      run_q  <= run_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    acc_q    <= acc_d;
    mcand_q  <= mcand_d;
    mplier_q <= mplier_d;
  end

  assign done_o = done_q;
  assign prod_o = acc_q;

endmodule

// ===== sv/min_cost_nonneg_diophantine_core.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// min_cost_nonneg_diophantine_core
// Cheapest exact non-negative split of a total into two pack sizes.
// ----------------------------------------------------------------------------
// Pulse start while busy is low to hand over one item; busy stays high until
// the result is shown. The result appears on result_o for exactly one cycle
// with result_valid_o high and must be taken then: the receiver cannot stall.
// An item with both sizes zero goes straight to the result. All other work runs
// on one shared bit-serial divider, narrow or double-width, used for every
// Euclid step of the gcd and of both modular inverses, and on one shared
// bit-serial multiplier used for every product.
// ----------------------------------------------------------------------------
module min_cost_nonneg_diophantine_core (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               start,
  output logic               busy,
  input  mcnd_pkg::in_item_t item_i,
  output logic               result_valid_o,
  output mcnd_pkg::result_t  result_o
);

  localparam int unsigned W  = mcnd_pkg::VALUE_W;
  localparam int unsigned WW = mcnd_pkg::WIDE_W;
  localparam int unsigned TW = mcnd_pkg::T_W;

  localparam logic [4:0] S_IDLE  = 5'd0;
  localparam logic [4:0] S_SPDIV = 5'd1;
  localparam logic [4:0] S_GCD   = 5'd2;
  localparam logic [4:0] S_NDIV  = 5'd3;
  localparam logic [4:0] S_K1DIV = 5'd4;
  localparam logic [4:0] S_K2DIV = 5'd5;
  localparam logic [4:0] S_INV0  = 5'd6;
  localparam logic [4:0] S_INVQ  = 5'd7;
  localparam logic [4:0] S_INVM  = 5'd8;
  localparam logic [4:0] S_XMUL  = 5'd9;
  localparam logic [4:0] S_XMOD  = 5'd10;
  localparam logic [4:0] S_PCHK  = 5'd11;
  localparam logic [4:0] S_YDIV  = 5'd12;
  localparam logic [4:0] S_C1A   = 5'd13;
  localparam logic [4:0] S_C1B   = 5'd14;
  localparam logic [4:0] S_C2A   = 5'd15;
  localparam logic [4:0] S_C2B   = 5'd16;
  localparam logic [4:0] S_OUT   = 5'd17;

  logic [4:0] state_q, state_d;

  logic [W-1:0] n_q, n_d, ca_q, ca_d, a_q, a_d, cb_q, cb_d, b_q, b_d;
  logic [W-1:0] r0_q, r0_d, r1_q, r1_d, r2_q, r2_d, g_q, g_d;
  logic [W-1:0] np_q, np_d, k1_q, k1_d, k2_q, k2_d, m_q, m_d;
  logic [W-1:0] x1_q, x1_d, y1_q, y1_d, x2_q, x2_d, y2_q, y2_d;
  logic [TW-1:0] t0_q, t0_d, t1_q, t1_d;
  logic [WW-1:0] acc_q, acc_d;
  logic [WW:0]   c1_q, c1_d, c2_sum;
  logic          sel_q, sel_d, azero_q, azero_d;
  mcnd_pkg::result_t res_q, res_d;
  logic          valid_q, valid_d;

  logic          div_go_q, div_go_d, div_wide_q, div_wide_d;
  logic [WW-1:0] div_x_q, div_x_d;
  logic [W-1:0]  div_y_q, div_y_d;
  logic          div_done;
  logic [WW-1:0] div_quot;
  logic [W-1:0]  div_rem;

  logic          mul_go_q, mul_go_d;
  logic [W-1:0]  mul_a_q, mul_a_d, mul_b_q, mul_b_d;
  logic          mul_done;
  logic [WW-1:0] mul_prod;

  logic [TW-1:0] t1_abs, prod_t, t_next, inv_t;
  logic [W-1:0]  inv;
  logic [WW-1:0] n_wide, rest;

  mcnd_div u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .go_i       (div_go_q),
    .wide_i     (div_wide_q),
    .dividend_i (div_x_q),
    .divisor_i  (div_y_q),
    .done_o     (div_done),
    .quot_o     (div_quot),
    .rem_o      (div_rem)
  );

  mcnd_mul u_mul (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .go_i   (mul_go_q),
    .a_i    (mul_a_q),
    .b_i    (mul_b_q),
    .done_o (mul_done),
    .prod_o (mul_prod)
  );

  assign t1_abs = t1_q[TW-1] ? (~t1_q + 1'b1) : t1_q;
  assign prod_t = mul_prod[TW-1:0];
  assign t_next = t1_q[TW-1] ? (t0_q + prod_t) : (t0_q - prod_t);
  assign inv_t  = t1_q[TW-1] ? (t1_q + TW'(m_q)) : t1_q;
  assign inv    = inv_t[W-1:0];
  assign n_wide = WW'(n_q);
  assign rest   = n_wide - mul_prod;
  assign c2_sum = {1'b0, acc_q} + {1'b0, mul_prod};

  always_comb begin
    state_d    = state_q;
    n_d = n_q; ca_d = ca_q; a_d = a_q; cb_d = cb_q; b_d = b_q;
    r0_d = r0_q; r1_d = r1_q; r2_d = r2_q; g_d = g_q;
    np_d = np_q; k1_d = k1_q; k2_d = k2_q; m_d = m_q;
    x1_d = x1_q; y1_d = y1_q; x2_d = x2_q; y2_d = y2_q;
    t0_d = t0_q; t1_d = t1_q; acc_d = acc_q; c1_d = c1_q;
    sel_d = sel_q; azero_d = azero_q; res_d = res_q;
    valid_d    = 1'b0;
    div_go_d   = 1'b0;
    div_wide_d = div_wide_q;
    div_x_d    = div_x_q;
    div_y_d    = div_y_q;
    mul_go_d   = 1'b0;
    mul_a_d    = mul_a_q;
    mul_b_d    = mul_b_q;

    case (state_q)
      S_IDLE: begin
        if (start) begin
          n_d  = item_i.total;
          ca_d = item_i.cost_a;
          a_d  = item_i.size_a;
          cb_d = item_i.cost_b;
          b_d  = item_i.size_b;
          res_d.failed  = 1'b1;
          res_d.count_a = '0;
          res_d.count_b = '0;
          div_wide_d    = 1'b0;
          div_x_d       = WW'(item_i.total);
          azero_d       = (item_i.size_a == '0);
          if (item_i.size_a == '0 && item_i.size_b == '0) begin
            res_d.failed = (item_i.total != '0);
            state_d      = S_OUT;
          end else if (item_i.size_a == '0) begin
            div_y_d  = item_i.size_b;
            div_go_d = 1'b1;
            state_d  = S_SPDIV;
          end else if (item_i.size_b == '0) begin
            div_y_d  = item_i.size_a;
            div_go_d = 1'b1;
            state_d  = S_SPDIV;
          end else begin
            r0_d     = item_i.size_a;
            r1_d     = item_i.size_b;
            div_x_d  = WW'(item_i.size_a);
            div_y_d  = item_i.size_b;
            div_go_d = 1'b1;
            state_d  = S_GCD;
          end
        end
      end
      S_SPDIV: begin
        if (div_done) begin
          if (div_rem == '0) begin
            res_d.failed = 1'b0;
            if (azero_q) begin
              res_d.count_b = div_quot[W-1:0];
            end else begin
              res_d.count_a = div_quot[W-1:0];
            end
          end
          state_d = S_OUT;
        end
      end
      S_GCD: begin
        if (div_done) begin
          r0_d = r1_q;
          r1_d = div_rem;
          if (div_rem == '0) begin
            g_d     = r1_q;
            div_x_d = n_wide;
            div_y_d = r1_q;
            state_d = S_NDIV;
          end else begin
            div_x_d = WW'(r1_q);
            div_y_d = div_rem;
            state_d = S_GCD;
          end
          div_go_d = 1'b1;
        end
      end
      S_NDIV: begin
        if (div_done) begin
          if (div_rem != '0) begin
            state_d = S_OUT;
          end else begin
            np_d     = div_quot[W-1:0];
            div_x_d  = WW'(b_q);
            div_y_d  = g_q;
            div_go_d = 1'b1;
            state_d  = S_K1DIV;
          end
        end
      end
      S_K1DIV: begin
        if (div_done) begin
          k1_d     = div_quot[W-1:0];
          div_x_d  = WW'(a_q);
          div_y_d  = g_q;
          div_go_d = 1'b1;
          state_d  = S_K2DIV;
        end
      end
      S_K2DIV: begin
        if (div_done) begin
          k2_d     = div_quot[W-1:0];
          m_d      = k1_q;
          sel_d    = 1'b0;
          div_x_d  = WW'(div_quot[W-1:0]);
          div_y_d  = k1_q;
          div_go_d = 1'b1;
          state_d  = S_INV0;
        end
      end
      S_INV0: begin
        if (div_done) begin
          r0_d = m_q;
          r1_d = div_rem;
          t0_d = '0;
          t1_d = (m_q == W'(1)) ? '0 : TW'(1);
          if (div_rem == '0) begin
            mul_a_d  = np_q;
            mul_b_d  = '0;
            mul_go_d = 1'b1;
            state_d  = S_XMUL;
          end else begin
            div_x_d  = WW'(m_q);
            div_y_d  = div_rem;
            div_go_d = 1'b1;
            state_d  = S_INVQ;
          end
        end
      end
      S_INVQ: begin
        if (div_done) begin
          r2_d     = div_rem;
          mul_a_d  = div_quot[W-1:0];
          mul_b_d  = t1_abs[W-1:0];
          mul_go_d = 1'b1;
          state_d  = S_INVM;
        end
      end
      S_INVM: begin
        if (mul_done) begin
          r0_d = r1_q;
          r1_d = r2_q;
          t0_d = t1_q;
          t1_d = t_next;
          if (r2_q == '0) begin
            mul_a_d  = np_q;
            mul_b_d  = inv;
            mul_go_d = 1'b1;
            state_d  = S_XMUL;
          end else begin
            div_x_d  = WW'(r1_q);
            div_y_d  = r2_q;
            div_go_d = 1'b1;
            state_d  = S_INVQ;
          end
        end
      end
      S_XMUL: begin
        if (mul_done) begin
          div_wide_d = 1'b1;
          div_x_d    = mul_prod;
          div_y_d    = m_q;
          div_go_d   = 1'b1;
          state_d    = S_XMOD;
        end
      end
      S_XMOD: begin
        if (div_done) begin
          mul_a_d = div_rem;
          if (sel_q) begin
            y2_d    = div_rem;
            mul_b_d = b_q;
          end else begin
            x1_d    = div_rem;
            mul_b_d = a_q;
          end
          mul_go_d = 1'b1;
          state_d  = S_PCHK;
        end
      end
      S_PCHK: begin
        if (mul_done) begin
          if (mul_prod > n_wide) begin
            state_d = S_OUT;
          end else begin
            div_wide_d = 1'b0;
            div_x_d    = rest;
            div_y_d    = sel_q ? a_q : b_q;
            div_go_d   = 1'b1;
            state_d    = S_YDIV;
          end
        end
      end
      S_YDIV: begin
        if (div_done) begin
          if (sel_q) begin
            x2_d     = div_quot[W-1:0];
            mul_a_d  = x1_q;
            mul_b_d  = ca_q;
            mul_go_d = 1'b1;
            state_d  = S_C1A;
          end else begin
            y1_d     = div_quot[W-1:0];
            sel_d    = 1'b1;
            m_d      = k2_q;
            div_x_d  = WW'(k1_q);
            div_y_d  = k2_q;
            div_go_d = 1'b1;
            state_d  = S_INV0;
          end
        end
      end
      S_C1A: begin
        if (mul_done) begin
          acc_d    = mul_prod;
          mul_a_d  = y1_q;
          mul_b_d  = cb_q;
          mul_go_d = 1'b1;
          state_d  = S_C1B;
        end
      end
      S_C1B: begin
        if (mul_done) begin
          c1_d     = c2_sum;
          mul_a_d  = x2_q;
          mul_b_d  = ca_q;
          mul_go_d = 1'b1;
          state_d  = S_C2A;
        end
      end
      S_C2A: begin
        if (mul_done) begin
          acc_d    = mul_prod;
          mul_a_d  = y2_q;
          mul_b_d  = cb_q;
          mul_go_d = 1'b1;
          state_d  = S_C2B;
        end
      end
      S_C2B: begin
        if (mul_done) begin
          res_d.failed = 1'b0;
          if (c1_q < c2_sum) begin
            res_d.count_a = x1_q;
            res_d.count_b = y1_q;
          end else begin
            res_d.count_a = x2_q;
            res_d.count_b = y2_q;
          end
          state_d = S_OUT;
        end
      end
      S_OUT: begin
        valid_d = 1'b1;
        state_d = S_IDLE;
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= S_IDLE;
      valid_q  <= 1'b0;
      div_go_q <= 1'b0;
      mul_go_q <= 1'b0;
    end else begin
      state_q  <= state_d;
      valid_q  <= valid_d;
      div_go_q <= div_go_d;
      mul_go_q <= mul_go_d;
    end
  end

  always_ff @(posedge clk_i) begin
    n_q <= n_d; ca_q <= ca_d; a_q <= a_d; cb_q <= cb_d; b_q <= b_d;
    r0_q <= r0_d; r1_q <= r1_d; r2_q <= r2_d; g_q <= g_d;
    np_q <= np_d; k1_q <= k1_d; k2_q <= k2_d; m_q <= m_d;
    x1_q <= x1_d; y1_q <= y1_d; x2_q <= x2_d; y2_q <= y2_d;
    t0_q <= t0_d; t1_q <= t1_d; acc_q <= acc_d; c1_q <= c1_d;
    sel_q <= sel_d; azero_q <= azero_d; res_q <= res_d;
    div_wide_q <= div_wide_d; div_x_q <= div_x_d; div_y_q <= div_y_d;
    mul_a_q <= mul_a_d; mul_b_q <= mul_b_d;
  end

  assign busy           = (state_q != S_IDLE);
  assign result_valid_o = valid_q;
  assign result_o       = res_q;

endmodule
